// ===== rtl/core/lphj_pkg.sv =====
// ----------------------------------------------------------------------------
// lphj_pkg
// Types and constants shared by the linear-probe hash join unit.
// ----------------------------------------------------------------------------
package lphj_pkg;

  localparam int KEY_W           = 32;
  localparam int DEF_LOG_SLOTS   = 12;
  localparam int CFG_W           = 4;
  localparam int QUEUE_DEPTH     = 2;
  localparam logic [KEY_W-1:0] HASH_MULT        = 32'h9E37_79B1;
  localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd12;

  // item kinds
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_PROBE = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic             last_item;
  } lphj_item_t;

  typedef struct packed {
    logic             hit;
    logic             table_full;
    logic [KEY_W-1:0] match_count;
  } lphj_result_t;

  localparam int ITEM_W = $bits(lphj_item_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } lphj_state_t;

endpackage

// ===== rtl/core/linear_probe_hash_join_unit.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_join_unit
// Open-addressed hash join table with linear probing, build and probe items.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the slot table clear, one slot per cycle, over
// all 2^LOG_SLOTS slots, and holds busy high meanwhile. An item is taken when
// start is high and busy is low. Each item gives exactly one result, shown on
// the result port for one cycle with done high; the receiver cannot stall it,
// so it must take every done pulse. With the walker free, an accepted item
// passes the hash multiply register, the queue and the slot walk before done
// rises. Per item the walker passes its idle state once and then walks k
// slots, where k is the number of slots the linear probe visits (1 up to the
// active slot count); the single read port of the slot RAM, checked once per
// cycle, paces the walk. The hash stage and a two-entry queue in front of the
// walker let the next items be taken while a walk is running. The user must
// write index_bits on the cfg channel only while the unit is idle; the block
// does not enforce it; 0 acts as 1, values above LOG_SLOTS act as LOG_SLOTS.
module linear_probe_hash_join_unit #(
  parameter int LOG_SLOTS = lphj_pkg::DEF_LOG_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst,
  // item channel
  input  logic                     start,
  output logic                     busy,
  input  lphj_pkg::lphj_item_t     cmd,
  // result channel
  output logic                     done,
  output lphj_pkg::lphj_result_t   result,
  // config channel (index_bits)
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [lphj_pkg::CFG_W-1:0] cfg_data
);
  import lphj_pkg::*;

  localparam int BW    = $clog2(LOG_SLOTS + 1);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMD_W = ITEM_W + LOG_SLOTS;

  logic [CFG_W-1:0]     index_bits;
  logic [BW-1:0]        bits;
  logic [LOG_SLOTS-1:0] mask;
  logic                 clearing;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_empty;
  logic [CNT_W-1:0]     q_count;
  logic [CMD_W-1:0]     q_wdata;
  logic [CMD_W-1:0]     q_rdata;

  // config register; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= INDEX_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      index_bits <= cfg_data;
    end
  end

  // active slot count exponent, clamped to 1..LOG_SLOTS
  always_comb begin
    if (index_bits == '0) begin
      bits = BW'(1);
    end else if (int'(index_bits) > LOG_SLOTS) begin
      bits = BW'(LOG_SLOTS);
    end else begin
      bits = BW'(index_bits);
    end
  end

  assign mask = {LOG_SLOTS{1'b1}} >> (BW'(LOG_SLOTS) - bits);

  lphj_front #(
    .LOG_SLOTS (LOG_SLOTS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .hold    (clearing),
    .busy    (busy),
    .cmd     (cmd),
    .bits    (bits),
    .q_count (q_count),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  lphj_queue #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  lphj_back #(
    .LOG_SLOTS (LOG_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .mask     (mask),
    .clearing (clearing),
    .done     (done),
    .result   (result)
  );

endmodule

// ===== rtl/core/lphj_ram.sv =====
// ----------------------------------------------------------------------------
// lphj_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lphj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lphj_front.sv =====
// ----------------------------------------------------------------------------
// lphj_front
// Accepts items, hashes the key to its home slot, pushes commands to queue.
// ----------------------------------------------------------------------------
module lphj_front #(
  parameter int LOG_SLOTS = lphj_pkg::DEF_LOG_SLOTS,
  parameter int BW        = $clog2(LOG_SLOTS + 1),
  parameter int CNT_W     = $clog2(lphj_pkg::QUEUE_DEPTH + 1)
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic                                    hold,
  output logic                                    busy,
  input  lphj_pkg::lphj_item_t                    cmd,
  input  logic [BW-1:0]                           bits,
  input  logic [CNT_W-1:0]                        q_count,
  output logic                                    q_push,
  output logic [lphj_pkg::ITEM_W+LOG_SLOTS-1:0]   q_data
);
  import lphj_pkg::*;

  logic             s1_valid;
  lphj_item_t       s1_item;
  logic [KEY_W-1:0] s1_prod;
  logic [5:0]       shamt;
  logic [KEY_W-1:0] hashed;
  logic             accept;

  // conservative: room for the staged item plus the new one, ignoring pops
  assign busy   = hold || ((int'(q_count) + int'(s1_valid)) >= QUEUE_DEPTH);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= cmd;
      s1_prod <= cmd.key * HASH_MULT;
    end
  end

  // home slot = top "bits" bits of the product
  assign shamt  = 6'd32 - 6'(bits);
  assign hashed = s1_prod >> shamt;

  assign q_push = s1_valid;
  assign q_data = {s1_item, hashed[LOG_SLOTS-1:0]};

endmodule

// ===== rtl/core/lphj_queue.sv =====
// ----------------------------------------------------------------------------
// lphj_queue
// Small register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module lphj_queue #(
  parameter int W     = 8,
  parameter int DEPTH = lphj_pkg::QUEUE_DEPTH,
  parameter int CNT_W = $clog2(DEPTH + 1),
  parameter int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [W-1:0]     wdata,
  input  logic             pop,
  output logic [W-1:0]     rdata,
  output logic             empty,
  output logic [CNT_W-1:0] count
);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic             do_pop;
  logic             do_push;

  assign empty   = (count == '0);
  assign do_pop  = pop && !empty;
  assign do_push = push && (int'(count) < DEPTH);
  assign rdata   = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (int'(tail) == DEPTH - 1) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (int'(head) == DEPTH - 1) ? '0 : head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= wdata;
    end
  end

endmodule

// ===== rtl/core/lphj_back.sv =====
// ----------------------------------------------------------------------------
// lphj_back
// Slot walker: clears the table after reset, then runs build and probe walks.
// ----------------------------------------------------------------------------
module lphj_back #(
  parameter int LOG_SLOTS = lphj_pkg::DEF_LOG_SLOTS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_empty,
  input  logic [lphj_pkg::ITEM_W+LOG_SLOTS-1:0]   q_data,
  output logic                                    q_pop,
  input  logic [LOG_SLOTS-1:0]                    mask,
  output logic                                    clearing,
  output logic                                    done,
  output lphj_pkg::lphj_result_t                  result
);
  import lphj_pkg::*;

  localparam int SLOT_W = KEY_W + 1;   // {valid, key}

  lphj_state_t          state, state_next;
  logic [LOG_SLOTS-1:0] clr_addr, clr_addr_next;
  lphj_item_t           cur, cur_next;
  logic [LOG_SLOTS-1:0] idx, idx_next;
  logic [LOG_SLOTS-1:0] n, n_next;
  logic [KEY_W-1:0]     match_cnt, match_cnt_next;
  logic                 done_next;
  lphj_result_t         result_next;

  lphj_item_t           head_item;
  logic [LOG_SLOTS-1:0] head_idx;

  logic                 we;
  logic [LOG_SLOTS-1:0] waddr;
  logic [SLOT_W-1:0]    wdata;
  logic [LOG_SLOTS-1:0] raddr;
  logic [SLOT_W-1:0]    rdata;
  logic                 slot_used;
  logic [KEY_W-1:0]     slot_key;
  logic                 last_slot;
  logic [KEY_W-1:0]     bumped;

  assign head_item = lphj_item_t'(q_data[ITEM_W+LOG_SLOTS-1 -: ITEM_W]);
  assign head_idx  = q_data[LOG_SLOTS-1:0];
  assign slot_used = rdata[SLOT_W-1];
  assign slot_key  = rdata[KEY_W-1:0];
  assign last_slot = (n == mask);
  assign bumped    = (match_cnt == '1) ? match_cnt : match_cnt + 1'b1;
  assign clearing  = (state == ST_CLEAR);

  lphj_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (1 << LOG_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    cur_next       = cur;
    idx_next       = idx;
    n_next         = n;
    match_cnt_next = match_cnt;
    done_next      = 1'b0;
    result_next    = result;
    q_pop          = 1'b0;
    we             = 1'b0;
    waddr          = idx;
    wdata          = {1'b1, cur.key};
    raddr          = idx;

    unique case (state)
      ST_CLEAR: begin
        we            = 1'b1;
        waddr         = clr_addr;
        wdata         = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        raddr = head_idx;
        if (!q_empty) begin
          q_pop      = 1'b1;
          cur_next   = head_item;
          idx_next   = head_idx;
          n_next     = '0;
          state_next = ST_WALK;
        end
      end

      ST_WALK: begin
        // read for the following slot goes out now; used only if we continue
        raddr = (idx + 1'b1) & mask;
        if (cur.kind == KIND_BUILD) begin
          if (!slot_used || last_slot) begin
            we          = !slot_used;
            done_next   = 1'b1;
            result_next = '{hit: !slot_used, table_full: slot_used,
                            match_count: match_cnt};
            state_next  = ST_IDLE;
          end
        end else begin
          if (!slot_used || (slot_key == cur.key) || last_slot) begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
            if (slot_used && (slot_key == cur.key)) begin
              result_next    = '{hit: 1'b1, table_full: 1'b0, match_count: bumped};
              match_cnt_next = bumped;
            end else begin
              result_next    = '{hit: 1'b0, table_full: 1'b0, match_count: match_cnt};
            end
            if (cur.last_item) begin
              match_cnt_next = '0;
            end
          end
        end
        if (state_next == ST_WALK) begin
          idx_next = (idx + 1'b1) & mask;
          n_next   = n + 1'b1;
        end
      end

      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      match_cnt <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      match_cnt <= match_cnt_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    idx    <= idx_next;
    n      <= n_next;
    result <= result_next;
  end

endmodule

// ===== rtl/core/lphj_checker.sv =====
// ----------------------------------------------------------------------------
// lphj_checker
// Port-level assertions for the hash join unit, bound to the top level.
// ----------------------------------------------------------------------------
module lphj_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input lphj_pkg::lphj_result_t result
);
  import lphj_pkg::*;

  logic [3:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(start && !busy) - 4'(done);
    end
  end

  // table clear sweep follows reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // walker passes through its idle state between results, so done never repeats back-to-back
  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back results");

  a_hit_full_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.hit && result.table_full))
    else $error("hit and table_full both set");

  // every result belongs to an accepted item
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> (pending != '0))
    else $error("result without an accepted item");

endmodule

bind linear_probe_hash_join_unit lphj_checker u_lphj_checker (.*);

// ===== tb/tb_linear_probe_hash_join_unit.sv =====
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_join_unit
// Self-checking bench for the linear-probe hash join unit. A shadow copy of
// the slot table and match counter predicts every result; build and probe
// items run in rounds under several table sizes, with random idle gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_probe_hash_join_unit;
  import lphj_pkg::*;

  localparam int          NUM_SLOTS     = 1 << DEF_LOG_SLOTS;
  localparam int unsigned SETTLE_CYCLES = 8;      // idle margin before a cfg write
  localparam int unsigned DRAIN_LIMIT   = 200000; // bound on the final wait
  localparam int unsigned ROUND_ITEMS   = 83;

  // --------------------------------------------------------------------------
  // Shadow of the join table: slot contents, match counter and index_bits.
  // take_item computes the result an accepted item must give; check_result
  // compares each done pulse with the oldest pending result.
  // --------------------------------------------------------------------------
  class join_table_shadow;
    bit               slot_used [NUM_SLOTS];
    logic [KEY_W-1:0] slot_key  [NUM_SLOTS];
    logic [KEY_W-1:0] match_total;
    logic [CFG_W-1:0] index_bits;
    lphj_result_t     pending_results [$];
    int unsigned      errors, items_seen, results_seen, probe_hits, dropped;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
      end
      match_total = '0;
      index_bits  = INDEX_BITS_RESET;
    endfunction

    function void set_index_bits(input logic [CFG_W-1:0] v);
      index_bits = v;
    endfunction

    function void take_item(input lphj_item_t it);
      int unsigned      bits, nslots, mask, idx;
      logic [KEY_W-1:0] h;
      lphj_result_t     want;
      // 0 acts as 1, anything above the table size acts as the table size
      bits = index_bits;
      if (bits < 1) bits = 1;
      if (bits > DEF_LOG_SLOTS) bits = DEF_LOG_SLOTS;
      nslots = 1 << bits;
      mask   = nslots - 1;
      h      = it.key * HASH_MULT;
      idx    = (h >> (KEY_W - bits)) & mask;
      want   = '0;
      if (it.kind == KIND_BUILD) begin
        for (int unsigned n = 0; n < nslots; n++) begin
          if (!slot_used[idx]) begin
            slot_used[idx] = 1'b1;
            slot_key[idx]  = it.key;
            want.hit       = 1'b1;
            break;
          end
          idx = (idx + 1) & mask;
        end
        want.table_full  = !want.hit;
        want.match_count = match_total;  // last mark ignored on a build
        if (!want.hit) dropped++;
      end else begin
        for (int unsigned n = 0; n < nslots; n++) begin
          if (!slot_used[idx]) break;
          if (slot_key[idx] == it.key) begin
            want.hit = 1'b1;
            break;
          end
          idx = (idx + 1) & mask;
        end
        if (want.hit && match_total != '1) match_total++;
        want.match_count = match_total;
        if (want.hit) probe_hits++;
        if (it.last_item) match_total = '0;
      end
      items_seen++;
      pending_results.push_back(want);
    endfunction

    function void check_result(input lphj_result_t got);
      lphj_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: hit=%0d table_full=%0d match_count=%0d",
               got.hit, got.table_full, got.match_count);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        errors++;
      end
      if (got.table_full !== want.table_full) begin
        $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
        errors++;
      end
      if (got.match_count !== want.match_count) begin
        $error("match_count: expected %0d, got %0d", want.match_count, got.match_count);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               start     = 1'b0;
  logic               busy;
  lphj_item_t         cmd       = '0;
  logic               done;
  lphj_result_t       result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data  = '0;

  join_table_shadow   board = new();
  logic [KEY_W-1:0]   key_pool [$];   // recently built keys, reused for hits
  bit                 no_idle   = 1'b0;
  int unsigned        cfg_writes = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  linear_probe_hash_join_unit #(
    .LOG_SLOTS (DEF_LOG_SLOTS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Results cannot be held off, so every done pulse is checked at the edge
  // that ends it. Values read right after the edge are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // start stays high between back-to-back items; it is only lowered when a
  // gap follows, so each edge sees at most one update of it.
  task automatic send_item(input logic kind, input logic [KEY_W-1:0] key,
                           input logic last);
    lphj_item_t  it;
    int unsigned gap;
    it.kind      = kind;
    it.key       = key;
    it.last_item = last;
    gap = no_idle ? 0 : idle_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= it;
    do @(posedge clk); while (busy);
    board.take_item(it);
  endtask

  // index_bits only changes with the unit idle: every pending result in,
  // plus a margin of SETTLE_CYCLES.
  task automatic write_index_bits(input logic [CFG_W-1:0] v);
    start <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_index_bits(v);
    cfg_writes++;
  endtask

  // Builds draw mostly fresh keys (some repeats for duplicates); probes
  // reuse built keys most of the time so that hits are common.
  function automatic logic [KEY_W-1:0] pick_key(input logic kind);
    logic [KEY_W-1:0] k;
    int unsigned      r;
    r = $urandom_range(0, 99);
    if (r < 3) return (r[0]) ? '1 : '0;
    if (key_pool.size() != 0 &&
        $urandom_range(0, 99) < ((kind == KIND_PROBE) ? 65 : 25)) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else begin
      k = $urandom();
      if (kind == KIND_BUILD) begin
        key_pool.push_back(k);
        if (key_pool.size() > 48) void'(key_pool.pop_front());
      end
    end
    return k;
  endfunction

  // One join round: a build stretch, then a probe stretch closed by a last
  // mark, with a sprinkle of out-of-order items and early last marks.
  task automatic run_join_round(input int unsigned n_items);
    int unsigned      n_build;
    logic             kind, last;
    logic [KEY_W-1:0] key;
    n_build = $urandom_range(n_items / 4, (n_items * 3) / 5);
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 8) kind = 1'($urandom_range(0, 1));
      else kind = (i < n_build) ? KIND_BUILD : KIND_PROBE;
      if (kind == KIND_BUILD) last = ($urandom_range(0, 9) == 0);
      else last = (i == n_items - 1) || ($urandom_range(0, 19) == 0);
      key = pick_key(kind);
      send_item(kind, key, last);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] round_bits [10];
    int unsigned      waited;
    round_bits = '{4'd3, 4'd12, 4'd1, 4'd6, 4'd15, 4'd0, 4'd2, 4'd8, 4'd12, 4'd5};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, at the reset table size: duplicates, extremes of the key,
    // a last mark on a build, counter clear on a last probe.
    send_item(KIND_BUILD, 32'h0000_0000, 1'b0);
    send_item(KIND_BUILD, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_BUILD, 32'h0000_0000, 1'b0);
    send_item(KIND_BUILD, 32'hA5A5_A5A5, 1'b1);
    send_item(KIND_PROBE, 32'h0000_0000, 1'b0);
    send_item(KIND_PROBE, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_PROBE, 32'h5A5A_5A5A, 1'b0);
    send_item(KIND_PROBE, 32'h0000_0000, 1'b1);
    send_item(KIND_PROBE, 32'hA5A5_A5A5, 1'b0);
    send_item(KIND_PROBE, 32'h1234_5678, 1'b1);

    // index_bits 0 acts as 1: the two low slots already hold both copies
    // of key 0, so the table is full without clearing it.
    write_index_bits(4'd0);
    send_item(KIND_BUILD, 32'h0BAD_F00D, 1'b0);
    send_item(KIND_PROBE, 32'h0000_0000, 1'b0);
    send_item(KIND_PROBE, 32'hDEAD_BEEF, 1'b1);   // miss after a full walk

    // above the table size acts as the table size; old entries come back
    write_index_bits(4'd15);
    send_item(KIND_PROBE, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_PROBE, 32'h0BAD_F00D, 1'b0);   // was dropped
    send_item(KIND_BUILD, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_PROBE, 32'hA5A5_A5A5, 1'b1);

    write_index_bits(4'd1);
    send_item(KIND_BUILD, 32'h0000_0001, 1'b0);
    send_item(KIND_PROBE, 32'h0000_0001, 1'b1);

    // Random rounds over several table sizes; some rounds run with no gaps.
    foreach (round_bits[r]) begin
      write_index_bits(round_bits[r]);
      no_idle = ($urandom_range(0, 3) == 0);
      run_join_round(ROUND_ITEMS);
    end
    no_idle = 1'b0;
    start <= 1'b0;

    // Let everything outstanding come back, bounded.
    waited = 0;
    while (board.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (board.pending_results.size() != 0) begin
      $error("%0d results never arrived", board.pending_results.size());
      board.errors++;
    end

    $display("covered %0d items under %0d index_bits writes, %0d results checked",
             board.items_seen, cfg_writes, board.results_seen);
    $display("%0d probe hits, %0d inserts dropped on a full table",
             board.probe_hits, board.dropped);
    if (board.errors == 0) begin
      $display("linear_probe_hash_join_unit regression: pass");
    end else begin
      $display("linear_probe_hash_join_unit regression: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run (clear sweep included),
  // even with every item walking the whole 4096-slot table.
  initial begin
    #200_000_000;
    $display("linear_probe_hash_join_unit regression: fail");
    $finish;
  end

endmodule
